FILE: hw/rtl/frame_stamped_input_ring_defines.svh
// Assertion macros used by the frame stamped input ring controller.
`ifndef FRAME_STAMPED_INPUT_RING_DEFINES_SVH
`define FRAME_STAMPED_INPUT_RING_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define FSIR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fsir assertion failed");
// Checked in every cycle, reset included.
`define FSIR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("fsir assertion failed");
`else
`define FSIR_ASSERT(lbl, prop)
`define FSIR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: hw/rtl/fsir_pkg.sv
// Package with constants, codes and types of the frame stamped input ring.
package fsir_pkg;

  localparam int MAX_PLAYERS = 8;
  localparam int RING_DEPTH  = 16;
  localparam int INPUT_BITS  = 32;

  localparam int PLAYER_BITS = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
  localparam int IDX_BITS    = $clog2(RING_DEPTH);
  localparam int SLOT_BITS   = PLAYER_BITS + IDX_BITS;
  localparam int SLOT_DEPTH  = MAX_PLAYERS * RING_DEPTH;
  localparam int VALUE_BITS  = (INPUT_BITS < 32) ? INPUT_BITS : 32;
  localparam int FRAME_BITS  = 32;
  localparam int ENTRY_BITS  = FRAME_BITS + VALUE_BITS;

  localparam logic [4:0] MAX_PLAYERS_W = 5'(MAX_PLAYERS);

  localparam logic [3:0]            PLAYERS_RESET = 4'd2;
  localparam logic [2:0]            LOCAL_RESET   = 3'd0;
  localparam logic [FRAME_BITS-1:0] NEVER_FRAME   = '1;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PLAYERS_IN_USE = 2'd0,
    REG_LOCAL_PLAYER   = 2'd1
  } fsir_reg_t;

  typedef enum logic [2:0] {
    FN_CLEAR        = 3'd0,
    FN_STORE_REMOTE = 3'd1,
    FN_DISCONNECT   = 3'd2,
    FN_READ         = 3'd3,
    FN_STORE_LOCAL  = 3'd4,
    FN_QUERY        = 3'd5
  } fsir_func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ID   = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_NO_MATCH = 2'd3
  } fsir_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsir_state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  player;
    logic [31:0] frame;
    logic [31:0] input_value;
  } fsir_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic        is_connected;
  } fsir_out_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } fsir_cmd_t;

endpackage

FILE: hw/rtl/frame_stamped_input_ring.sv
// Results are registered in execute, after their transfer, once the output is free.
// A new item is taken only in the idle state; the slot store is read in the
// capture cycle (registered read) and checked and written in the execute cycle.
// A waiting result does not block the next transfer, only the next execute.
// Reset (synchronous): all slots invalid, all players connected, drop frames
// set to never, players_in_use = 2, local_player = 0; no clearing pass.
module frame_stamped_input_ring (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fsir_pkg::fsir_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fsir_pkg::fsir_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fsir_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fsir_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import fsir_pkg::*;

  fsir_cmd_t cmd;

  // Registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  fsir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  fsir_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

endmodule

FILE: hw/rtl/fsir_ram.sv
// Generic single write port RAM with registered read.
module fsir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/fsir_ctrl.sv
// Controller: sequences slot lookup and execute, owns the result valid flag.
`include "frame_stamped_input_ring_defines.svh"

module fsir_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output fsir_pkg::fsir_cmd_t cmd
);
  import fsir_pkg::*;

  fsir_state_t state, state_next;
  logic        out_valid_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == S_IDLE);
    cmd.capture = (state == S_IDLE) && in_valid;
    // Hold the result stage until the previous result has been taken.
    cmd.execute = (state == S_EXEC) && (!out_valid || out_ready);
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.execute) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `FSIR_ASSERT(a_exec_loads_result, cmd.execute |=> out_valid)
  `FSIR_ASSERT(a_capture_enters_exec, cmd.capture |=> (state == S_EXEC))
  `FSIR_ASSERT(a_one_in_flight, (state == S_EXEC) |-> !in_ready && !cmd.capture)
  `FSIR_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE) && !out_valid)

endmodule

FILE: hw/rtl/fsir_dp.sv
// Datapath: slot store, valid marks, player state, config and result register.
module fsir_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fsir_pkg::fsir_cmd_t                    cmd,
  input  fsir_pkg::fsir_in_t                     in_data,
  output fsir_pkg::fsir_out_t                    out_data,
  input  logic                                   cfg_valid,
  input  logic [fsir_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [fsir_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import fsir_pkg::*;

  // configuration
  logic [3:0] players_in_use;
  logic [2:0] local_player;

  // captured operation
  logic [2:0]            op_func;
  logic [3:0]            op_player;
  logic [FRAME_BITS-1:0] op_frame;
  logic [VALUE_BITS-1:0] op_value;

  // state
  logic [SLOT_DEPTH-1:0] slot_valid;
  logic [MAX_PLAYERS-1:0] player_connected;
  logic [FRAME_BITS-1:0]  player_drop_frame [MAX_PLAYERS];

  // slot store access
  logic [SLOT_BITS-1:0]  raddr;
  logic [SLOT_BITS-1:0]  waddr;
  logic [ENTRY_BITS-1:0] rdata;
  logic                  wr;

  logic [PLAYER_BITS-1:0] pid;
  logic [PLAYER_BITS-1:0] tgt;
  logic [IDX_BITS-1:0]    slot_idx;
  logic                   id_ok;
  logic                   local_ok;
  logic                   hit_valid;
  logic [FRAME_BITS-1:0]  stored_frame;
  logic [VALUE_BITS-1:0]  stored_value;
  logic                   conn;
  logic [FRAME_BITS-1:0]  drop;
  logic                   clr;
  logic                   disc;
  fsir_out_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      players_in_use <= PLAYERS_RESET;
      local_player   <= LOCAL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PLAYERS_IN_USE: players_in_use <= cfg_data;
        REG_LOCAL_PLAYER:   local_player   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func   <= in_data.func;
      op_player <= in_data.player;
      op_frame  <= in_data.frame;
      op_value  <= in_data.input_value[VALUE_BITS-1:0];
    end
  end

  // Look up the slot while the operation is captured; data is ready in execute.
  assign raddr = {PLAYER_BITS'(in_data.player), in_data.frame[IDX_BITS-1:0]};

  fsir_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(SLOT_DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (cmd.execute && wr),
    .waddr(waddr),
    .wdata({op_frame, op_value}),
    .re   (cmd.capture),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    pid          = PLAYER_BITS'(op_player);
    slot_idx     = op_frame[IDX_BITS-1:0];
    id_ok        = ({1'b0, op_player} < {1'b0, players_in_use})
                   && ({1'b0, op_player} < MAX_PLAYERS_W);
    local_ok     = ({2'b00, local_player} < MAX_PLAYERS_W);
    tgt          = (fsir_func_t'(op_func) == FN_STORE_LOCAL) ? PLAYER_BITS'(local_player) : pid;
    waddr        = {tgt, slot_idx};
    hit_valid    = slot_valid[{pid, slot_idx}];
    stored_frame = rdata[VALUE_BITS +: FRAME_BITS];
    stored_value = rdata[VALUE_BITS-1:0];
    conn         = player_connected[pid];
    drop         = player_drop_frame[pid];
  end

  always_comb begin
    res  = '0;
    wr   = 1'b0;
    clr  = 1'b0;
    disc = 1'b0;
    unique case (fsir_func_t'(op_func))
      FN_CLEAR: clr = 1'b1;
      FN_STORE_REMOTE: begin
        if (!id_ok) begin
          res.status = ST_BAD_ID;
        end else if (!conn && (op_frame > drop)) begin
          res.status = ST_DROPPED;
        end else if (hit_valid && (stored_frame >= op_frame)) begin
          res.status = ST_NO_MATCH;
        end else begin
          wr = 1'b1;
        end
      end
      FN_DISCONNECT: begin
        if (!id_ok) begin
          res.status = ST_BAD_ID;
        end else begin
          disc = 1'b1;
        end
      end
      FN_READ: begin
        if (!id_ok) begin
          res.status = ST_BAD_ID;
        end else if (!conn && (op_frame >= drop)) begin
          res.status = ST_DROPPED;
        end else if (!hit_valid || (stored_frame != op_frame)) begin
          res.status = ST_NO_MATCH;
        end else begin
          res.read_value = 32'(stored_value);
        end
      end
      FN_STORE_LOCAL: begin
        if (!local_ok) begin
          res.status = ST_BAD_ID;
        end else begin
          wr = 1'b1;
        end
      end
      FN_QUERY: begin
        if (!id_ok) begin
          res.status = ST_BAD_ID;
        end else begin
          res.is_connected = conn || (op_frame < drop);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.execute && clr)) begin
      slot_valid <= '0;
    end else if (cmd.execute && wr) begin
      slot_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.execute && clr)) begin
      player_connected <= '1;
      for (int i = 0; i < MAX_PLAYERS; i++) begin
        player_drop_frame[i] <= NEVER_FRAME;
      end
    end else if (cmd.execute && disc) begin
      player_connected[pid]  <= 1'b0;
      player_drop_frame[pid] <= op_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_data <= res;
    end
  end

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the frame stamped input ring: directed table, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fsir_pkg::*;

  // Function codes with no operation behind them.
  localparam logic [2:0] FN_SPARE_LO = 3'd6;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    SINK_FREE,
    SINK_COIN,
    SINK_THIRD,
    SINK_SPARSE
  } sink_mode_t;

  typedef struct {
    fsir_out_t res;
    int        seq;
  } awaited_t;

  typedef struct {
    fsir_in_t  op;
    bit        typed;
    fsir_out_t want;
  } probe_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  fsir_in_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  fsir_out_t                 out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Mirror of the ring contents and the session setup.
  bit        ring_valid [MAX_PLAYERS][RING_DEPTH];
  bit [31:0] ring_frame [MAX_PLAYERS][RING_DEPTH];
  bit [31:0] ring_value [MAX_PLAYERS][RING_DEPTH];
  bit        peer_online [MAX_PLAYERS];
  bit [31:0] peer_drop [MAX_PLAYERS];
  bit [3:0]  session_players;
  bit [2:0]  local_seat;

  awaited_t   awaited[$];
  int         mismatch_count = 0;
  int         items_sent = 0;
  int         results_seen = 0;
  int         cfg_writes = 0;
  int         func_seen [8];
  int         status_seen [4];
  int unsigned sink_tick = 0;
  sink_mode_t  sink_mode = SINK_FREE;

  frame_stamped_input_ring dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic note_mismatch(string what, int seq, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t: %s, item %0d: got %h, want %h", $time, what, seq, got, want);
  endtask

  function automatic void wipe_rings();
    foreach (ring_valid[p, s]) begin
      ring_valid[p][s] = 1'b0;
      ring_frame[p][s] = '0;
      ring_value[p][s] = '0;
    end
    foreach (peer_online[p]) begin
      peer_online[p] = 1'b1;
      peer_drop[p] = NEVER_FRAME;
    end
  endfunction

  // Work out the result of one operation and advance the mirror.
  function automatic fsir_out_t ring_outcome(fsir_in_t op);
    fsir_out_t           r;
    logic [IDX_BITS-1:0] s;
    int unsigned         p;
    bit                  seat_ok;
    r = '0;
    s = op.frame[IDX_BITS-1:0];
    p = op.player;
    seat_ok = (p < session_players) && (p < MAX_PLAYERS);
    case (op.func)
      FN_CLEAR: wipe_rings();
      FN_STORE_REMOTE: begin
        if (!seat_ok) begin
          r.status = ST_BAD_ID;
        end else if (!peer_online[p] && op.frame > peer_drop[p]) begin
          r.status = ST_DROPPED;
        end else if (ring_valid[p][s] && ring_frame[p][s] >= op.frame) begin
          r.status = ST_NO_MATCH;
        end else begin
          ring_valid[p][s] = 1'b1;
          ring_frame[p][s] = op.frame;
          ring_value[p][s] = op.input_value;
        end
      end
      FN_DISCONNECT: begin
        if (!seat_ok) begin
          r.status = ST_BAD_ID;
        end else begin
          peer_online[p] = 1'b0;
          peer_drop[p] = op.frame;
        end
      end
      FN_READ: begin
        if (!seat_ok) begin
          r.status = ST_BAD_ID;
        end else if (!peer_online[p] && op.frame >= peer_drop[p]) begin
          r.status = ST_DROPPED;
        end else if (!ring_valid[p][s] || ring_frame[p][s] != op.frame) begin
          r.status = ST_NO_MATCH;
        end else begin
          r.read_value = ring_value[p][s];
        end
      end
      FN_STORE_LOCAL: begin
        if (local_seat >= MAX_PLAYERS) begin
          r.status = ST_BAD_ID;
        end else begin
          ring_valid[local_seat][s] = 1'b1;
          ring_frame[local_seat][s] = op.frame;
          ring_value[local_seat][s] = op.input_value;
        end
      end
      FN_QUERY: begin
        if (!seat_ok)
          r.status = ST_BAD_ID;
        else
          r.is_connected = peer_online[p] || (op.frame < peer_drop[p]);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic probe_t probe(logic [2:0] f, logic [3:0] pl, logic [31:0] fr,
                                   logic [31:0] val, bit typed = 1'b0,
                                   fsir_status_t st = ST_OK, logic [31:0] rv = '0,
                                   logic conn = 1'b0);
    probe_t t;
    t.op = '{func: f, player: pl, frame: fr, input_value: val};
    t.typed = typed;
    t.want = '{status: st, read_value: rv, is_connected: conn};
    return t;
  endfunction

  // Hold the item until its transfer, then record what it should produce.
  task automatic push_item(fsir_in_t op, bit typed, fsir_out_t want);
    awaited_t a;
    in_valid <= 1'b1;
    in_data <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    a.res = ring_outcome(op);
    if (typed) a.res = want;
    a.seq = items_sent;
    awaited.push_back(a);
    items_sent++;
    func_seen[op.func]++;
  endtask

  task automatic idle_sender(int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic write_reg(fsir_reg_t which, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (which == REG_PLAYERS_IN_USE)
      session_players = data;
    else
      local_seat = data[2:0];
    cfg_writes++;
  endtask

  // Drain every result, let the pipeline go quiet, then reprogram.
  task automatic set_session(logic [3:0] players, logic [2:0] seat);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_PLAYERS_IN_USE, players);
    write_reg(REG_LOCAL_PLAYER, {1'b0, seat});
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic run_phase(logic [3:0] players, logic [2:0] seat, int unsigned count);
    bit [31:0]   head [MAX_PLAYERS];
    bit [31:0]   base;
    fsir_in_t    op;
    fsir_out_t   none;
    int unsigned roll, burst, left, seats, p, hp, s;
    set_session(players, seat);
    seats = (players > MAX_PLAYERS) ? MAX_PLAYERS : players;
    case ($urandom_range(0, 3))
      0: base = 32'd0;
      1: base = NEVER_FRAME - 32'd60;
      default: base = $urandom;
    endcase
    foreach (head[i]) head[i] = base + 32'($urandom_range(0, 8));
    none = '0;
    left = count;
    while (left != 0) begin
      burst = $urandom_range(1, 16);
      while (burst != 0 && left != 0) begin
        p = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, seats - 1);
        hp = (p < MAX_PLAYERS) ? p : 0;
        op.player = 4'(p);
        op.input_value = $urandom;
        op.frame = head[hp] + 32'($urandom_range(0, 24)) - 32'd16;
        if ($urandom_range(0, 19) == 0) op.frame = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          op.func = FN_STORE_REMOTE;
          if ($urandom_range(0, 2) == 0) head[hp] += 32'($urandom_range(1, 3));
        end else if (roll < 54) begin
          op.func = FN_READ;
          // aim at a frame that is actually held in the ring
          s = $urandom_range(0, RING_DEPTH - 1);
          if (ring_valid[hp][s] && $urandom_range(0, 1)) op.frame = ring_frame[hp][s];
        end else if (roll < 66) begin
          op.func = FN_STORE_LOCAL;
          op.player = 4'($urandom_range(0, 15));
          op.frame = head[seat] + 32'($urandom_range(0, 24)) - 32'd16;
          if ($urandom_range(0, 3) == 0) head[seat] += 32'($urandom_range(1, 3));
        end else if (roll < 78) begin
          op.func = FN_QUERY;
          if (!peer_online[hp]) op.frame = peer_drop[hp] + 32'($urandom_range(0, 2)) - 32'd1;
        end else if (roll < 85) begin
          op.func = FN_DISCONNECT;
        end else if (roll < 88) begin
          op.func = FN_CLEAR;
        end else if (roll < 91) begin
          op.func = $urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO;
        end else begin
          // straddle the drop frame of a disconnected player
          op.func = $urandom_range(0, 1) ? FN_STORE_REMOTE : FN_READ;
          if (!peer_online[hp]) op.frame = peer_drop[hp] + 32'($urandom_range(0, 2)) - 32'd1;
        end
        push_item(op, 1'b0, none);
        burst--;
        left--;
      end
      idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    end
  endtask

  // Receiver: switch between free flow and several stall patterns.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      sink_tick <= sink_tick + 1;
      if (sink_tick % 97 == 0) sink_mode <= sink_mode_t'($urandom_range(0, 3));
      case (sink_mode)
        SINK_FREE: out_ready <= 1'b1;
        SINK_COIN: out_ready <= 1'($urandom_range(0, 1));
        SINK_THIRD: out_ready <= (sink_tick % 3 == 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    awaited_t a;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      status_seen[out_data.status]++;
      if (awaited.size() == 0) begin
        note_mismatch("result with nothing pending", -1, out_data.status, 0);
      end else begin
        a = awaited.pop_front();
        if (out_data.status !== a.res.status)
          note_mismatch("status", a.seq, out_data.status, a.res.status);
        if (out_data.read_value !== a.res.read_value)
          note_mismatch("read_value", a.seq, out_data.read_value, a.res.read_value);
        if (out_data.is_connected !== a.res.is_connected)
          note_mismatch("is_connected", a.seq, out_data.is_connected, a.res.is_connected);
      end
    end
  end

  initial begin
    probe_t      probes[$];
    int unsigned k;
    wipe_rings();
    session_players = PLAYERS_RESET;
    local_seat = LOCAL_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Session at reset: two players, local seat zero.
    probes.push_back(probe(FN_QUERY, 4'd0, 32'd0, 32'd0, 1'b1, ST_OK, '0, 1'b1));
    probes.push_back(probe(FN_READ, 4'd0, 32'd0, 32'd0, 1'b1, ST_NO_MATCH));
    probes.push_back(probe(FN_STORE_REMOTE, 4'd1, NEVER_FRAME, '1, 1'b1, ST_OK));
    probes.push_back(probe(FN_READ, 4'd1, NEVER_FRAME, 32'd0, 1'b1, ST_OK, '1));
    // equal and older frames in an occupied slot are stale
    probes.push_back(probe(FN_STORE_REMOTE, 4'd1, NEVER_FRAME, 32'd0, 1'b1, ST_NO_MATCH));
    probes.push_back(probe(FN_STORE_REMOTE, 4'd1, 32'h0000_000F, 32'd7, 1'b1, ST_NO_MATCH));
    probes.push_back(probe(FN_STORE_REMOTE, 4'd2, 32'd5, 32'd1, 1'b1, ST_BAD_ID));
    probes.push_back(probe(FN_STORE_LOCAL, 4'd15, 32'd0, 32'hA5A5_A5A5, 1'b1, ST_OK));
    probes.push_back(probe(FN_READ, 4'd0, 32'd0, 32'd0, 1'b1, ST_OK, 32'hA5A5_A5A5));
    probes.push_back(probe(FN_READ, 4'd0, 32'd16, 32'd0, 1'b1, ST_NO_MATCH));
    probes.push_back(probe(FN_STORE_REMOTE, 4'd0, 32'd32, 32'h0000_0001));
    // local store overwrites even a newer frame
    probes.push_back(probe(FN_STORE_LOCAL, 4'd0, 32'd16, 32'h8000_0000));
    probes.push_back(probe(FN_READ, 4'd0, 32'd16, 32'd0));
    probes.push_back(probe(FN_DISCONNECT, 4'd1, 32'd100, 32'd0, 1'b1, ST_OK));
    probes.push_back(probe(FN_QUERY, 4'd1, 32'd99, 32'd0, 1'b1, ST_OK, '0, 1'b1));
    probes.push_back(probe(FN_QUERY, 4'd1, 32'd100, 32'd0, 1'b1, ST_OK, '0, 1'b0));
    probes.push_back(probe(FN_STORE_REMOTE, 4'd1, 32'd100, 32'h1234_5678));
    probes.push_back(probe(FN_STORE_REMOTE, 4'd1, 32'd101, 32'd0, 1'b1, ST_DROPPED));
    probes.push_back(probe(FN_READ, 4'd1, 32'd100, 32'd0, 1'b1, ST_DROPPED));
    // a second disconnect moves the drop frame
    probes.push_back(probe(FN_DISCONNECT, 4'd1, NEVER_FRAME, 32'd0, 1'b1, ST_OK));
    probes.push_back(probe(FN_READ, 4'd1, 32'd100, 32'd0));
    probes.push_back(probe(FN_QUERY, 4'd1, NEVER_FRAME, 32'd0, 1'b1, ST_OK, '0, 1'b0));
    probes.push_back(probe(FN_DISCONNECT, 4'd9, 32'd0, 32'd0, 1'b1, ST_BAD_ID));
    probes.push_back(probe(FN_SPARE_HI, 4'd15, NEVER_FRAME, '1, 1'b1, ST_OK));
    probes.push_back(probe(FN_CLEAR, 4'd0, 32'd0, 32'd0, 1'b1, ST_OK));
    probes.push_back(probe(FN_READ, 4'd1, 32'd100, 32'd0, 1'b1, ST_NO_MATCH));
    foreach (probes[i]) begin
      push_item(probes[i].op, probes[i].typed, probes[i].want);
      idle_sender(($urandom_range(0, 2) == 0) ? 1 : 0);
    end

    run_phase(4'd8, 3'd7, 220);
    run_phase(4'd1, 3'd0, 180);
    run_phase(4'd3, 3'd5, 220);
    run_phase(4'd15, 3'd2, 220);
    run_phase(4'd5, 3'd4, 220);
    run_phase(4'd8, 3'd0, 220);
    run_phase(4'd2, 3'd7, 220);

    in_valid <= 1'b0;
    k = 0;
    while (awaited.size() != 0 && k < 20000) begin
      @(posedge clk);
      k++;
    end
    repeat (6) @(posedge clk);
    foreach (awaited[i]) note_mismatch("result never arrived", awaited[i].seq, 0, 0);

    $display("%0d operations: clear %0d, remote %0d, disconnect %0d, read %0d, local %0d,",
             items_sent, func_seen[FN_CLEAR], func_seen[FN_STORE_REMOTE],
             func_seen[FN_DISCONNECT], func_seen[FN_READ], func_seen[FN_STORE_LOCAL]);
    $display("query %0d, spare %0d; %0d reg writes; results ok/bad/drop/stale %0d/%0d/%0d/%0d",
             func_seen[FN_QUERY], func_seen[FN_SPARE_LO] + func_seen[FN_SPARE_HI], cfg_writes,
             status_seen[ST_OK], status_seen[ST_BAD_ID], status_seen[ST_DROPPED],
             status_seen[ST_NO_MATCH]);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
